[src/vrt_pkg.sv]
package vrt_pkg;

	localparam int POS_W   = 22;
	localparam int POSY_W  = 23;
	localparam int DIR_W   = 18;
	localparam int MAG_W   = 18;
	localparam int VOX_W   = 6;
	localparam int FACE_W  = 3;
	localparam int REACH_W = 23;
	localparam int EYE_W   = 19;
	// walk cell counters: start cell plus worst-case step count, signed
	localparam int CELL_W  = 26;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic REG_REACH = 1'b0;
	localparam logic REG_EYE   = 1'b1;

	localparam logic [REACH_W-1:0] REACH_RST = 23'd327680;
	localparam logic [EYE_W-1:0]   EYE_RST   = 19'd104858;

	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd2;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd3;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd5;

	typedef struct packed {
		logic                    op;
		logic [VOX_W-1:0]        vx;
		logic [VOX_W-1:0]        vy;
		logic [VOX_W-1:0]        vz;
		logic                    present;
		logic [POS_W-1:0]        px;
		logic [POSY_W-1:0]       py;
		logic [POS_W-1:0]        pz;
		logic signed [DIR_W-1:0] dx;
		logic signed [DIR_W-1:0] dy;
		logic signed [DIR_W-1:0] dz;
	} vrt_item_t;

	typedef struct packed {
		logic              hit;
		logic [VOX_W-1:0]  x;
		logic [VOX_W-1:0]  y;
		logic [VOX_W-1:0]  z;
		logic [FACE_W-1:0] face;
	} vrt_result_t;

endpackage

[src/voxel_ray_traversal_unit.sv]
// Voxel ray caster over a one-bit occupancy map using a 3D DDA walk. Items
// enter through a push/full queue port and are buffered in a two-word queue;
// a write word sets or clears one voxel and produces no result, a cast word
// produces exactly one result word, read through the empty/pop port. A write
// is done in the back end as its word is popped. A cast runs, per axis with a
// nonzero direction, two serial divisions on a shared divider, then one map
// read and one check and step per visited cell, and then issues the result.
// After reset the map is cleared one cell per cycle over all
// GRID_SIDE*GRID_SIDE*GRID_HEIGHT cells (262144 by default); full stays high
// until that pass ends.
// Configuration registers (reach, eye height) may be written only while idle.
module voxel_ray_traversal_unit #(
	parameter int GRID_SIDE   = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [22:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [5:0]          voxel_x,
	input  logic [5:0]          voxel_y,
	input  logic [5:0]          voxel_z,
	input  logic                voxel_present,
	input  logic [21:0]         foot_x,
	input  logic [21:0]         foot_y,
	input  logic [21:0]         foot_z,
	input  logic signed [17:0]  dir_x,
	input  logic signed [17:0]  dir_y,
	input  logic signed [17:0]  dir_z,
	output logic                empty,
	input  logic                pop,
	output logic                hit,
	output logic [5:0]          hit_x,
	output logic [5:0]          hit_y,
	output logic [5:0]          hit_z,
	output logic [2:0]          struck_face
);
	import vrt_pkg::*;

	logic [REACH_W-1:0] reach_q;
	logic [EYE_W-1:0]   eye_q;
	vrt_item_t          in_item;
	vrt_item_t          q_item;
	logic               q_full;
	logic               q_valid;
	logic               q_pop;
	logic               clearing;
	vrt_result_t        res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= REACH_RST;
			eye_q   <= EYE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REACH: reach_q <= cfg_data;
				REG_EYE:   eye_q   <= cfg_data[EYE_W-1:0];
				default:   reach_q <= reach_q;
			endcase
		end
	end

	always_comb begin
		in_item.op      = operation;
		in_item.vx      = voxel_x;
		in_item.vy      = voxel_y;
		in_item.vz      = voxel_z;
		in_item.present = voxel_present;
		in_item.px      = foot_x;
		in_item.py      = {1'b0, foot_y};
		in_item.pz      = foot_z;
		in_item.dx      = dir_x;
		in_item.dy      = dir_y;
		in_item.dz      = dir_z;
	end

	// no words taken while the map clear runs
	assign full = q_full || clearing;

	vrt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && !full),
		.in_item    (in_item),
		.eye_height (eye_q),
		.q_full     (q_full),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	vrt_back #(
		.GRID_SIDE   (GRID_SIDE),
		.GRID_HEIGHT (GRID_HEIGHT),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.reach    (reach_q),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (res)
	);

	assign hit         = res.hit;
	assign hit_x       = res.x;
	assign hit_y       = res.y;
	assign hit_z       = res.z;
	assign struck_face = res.face;
endmodule

[src/vrt_ram.sv]
module vrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/vrt_div.sv]
module vrt_div #(
	parameter int NW = 33,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [DW:0]     r2;
	logic            ge;

	// restoring, one quotient bit per cycle
	assign r2 = {rem_q, num_q[NW-1]};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(r2 - {1'b0, den_q}) : DW'(r2);
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule

[src/vrt_front.sv]
module vrt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  vrt_pkg::vrt_item_t      in_item,
	input  logic [vrt_pkg::EYE_W-1:0] eye_height,
	output logic                    q_full,
	output logic                    q_valid,
	output vrt_pkg::vrt_item_t      q_item,
	input  logic                    q_pop
);
	import vrt_pkg::*;

	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	vrt_item_t  ent_q [2];
	vrt_item_t  dec;

	// ray origin: eye height added to the foot y once, at entry
	always_comb begin
		dec    = in_item;
		dec.py = in_item.py + POSY_W'(eye_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push && !q_full) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'((push && !q_full) ? 1 : 0) - 2'((q_pop && q_valid) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !q_full) begin
			ent_q[wr_q] <= dec;
		end
	end

	assign q_full  = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_item  = ent_q[rd_q];
endmodule

[src/vrt_back.sv]
module vrt_back #(
	parameter int GRID_SIDE   = 64,
	parameter int GRID_HEIGHT = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  vrt_pkg::vrt_item_t          q_item,
	output logic                        q_pop,
	input  logic [vrt_pkg::REACH_W-1:0] reach,
	output logic                        clearing,
	output logic                        empty,
	input  logic                        pop,
	output vrt_pkg::vrt_result_t        result
);
	import vrt_pkg::*;

	localparam int MAP_CELLS = GRID_SIDE * GRID_SIDE * GRID_HEIGHT;
	localparam int AW = $clog2(MAP_CELLS);
	localparam int NW = 2 * FRAC_BITS + 1;
	localparam int TW = ((2 * FRAC_BITS > REACH_W) ? 2 * FRAC_BITS : REACH_W) + 2;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SETUP = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]               state_q;
	logic [AW-1:0]            clr_q;
	logic [POSY_W-1:0]        pos_q [3];
	logic [MAG_W-1:0]         mag_q [3];
	logic                     dpos_q [3];
	logic signed [CELL_W-1:0] cell_q [3];
	logic [TW-1:0]            tm_q [3];
	logic                     tmi_q [3];
	logic [TW-1:0]            td_q [3];
	logic                     tdi_q [3];
	logic [TW-1:0]            t_q;
	logic                     ti_q;
	logic [1:0]               ax_q;
	logic                     ph_q;
	logic                     ing_q;
	vrt_result_t              res_q;
	vrt_result_t              out_q;
	logic                     outv_q;

	logic [POSY_W-1:0]        pos_in [3];
	logic signed [DIR_W-1:0]  dir_in [3];
	logic [FRAC_BITS:0]       bdist;
	logic [NW-1:0]            div_num;
	logic                     div_start;
	logic                     div_done;
	logic [NW-1:0]            div_quo;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic                     ram_rdata;
	logic                     wr_ok;
	logic                     walk_ok;
	logic                     cell_in;
	logic [1:0]               step_ax;
	logic signed [TW:0]       lc [3];
	logic [FACE_W-1:0]        face;

	function automatic logic lt_u(input logic [TW-1:0] a, input logic ai,
	                              input logic [TW-1:0] b, input logic bi);
		return !ai && (bi || a < b);
	endfunction

	function automatic logic lt_s(input logic signed [TW:0] a, input logic ai,
	                              input logic signed [TW:0] b, input logic bi);
		return !ai && (bi || a < b);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] x,
	                                           input logic [AW-1:0] y,
	                                           input logic [AW-1:0] z);
		return AW'(x * (GRID_HEIGHT * GRID_SIDE) + y * GRID_SIDE + z);
	endfunction

	always_comb begin
		pos_in[0] = {1'b0, q_item.px};
		pos_in[1] = q_item.py;
		pos_in[2] = {1'b0, q_item.pz};
		dir_in[0] = q_item.dx;
		dir_in[1] = q_item.dy;
		dir_in[2] = q_item.dz;
	end

	// distance to the next border along the step, then the two quotients
	assign bdist = dpos_q[ax_q] ? (FRAC_BITS + 1)'((1 << FRAC_BITS) - pos_q[ax_q][FRAC_BITS-1:0])
	                            : {1'b0, pos_q[ax_q][FRAC_BITS-1:0]};
	assign div_num = ph_q ? NW'(1) << (2 * FRAC_BITS) : NW'({bdist, {FRAC_BITS{1'b0}}});
	assign div_start = state_q == S_SETUP && mag_q[ax_q] != '0;

	vrt_div #(.NW(NW), .DW(MAG_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (mag_q[ax_q]),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign wr_ok = q_item.vx < GRID_SIDE && q_item.vy < GRID_HEIGHT && q_item.vz < GRID_SIDE;
	assign q_pop = state_q == S_IDLE && q_valid;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (q_pop && q_item.op == OP_WRITE && wr_ok) begin
			ram_we    = 1'b1;
			ram_waddr = addr_of(AW'(q_item.vx), AW'(q_item.vy), AW'(q_item.vz));
			ram_wdata = q_item.present;
		end
	end

	assign cell_in = cell_q[0] >= 0 && cell_q[0] < GRID_SIDE &&
	                 cell_q[1] >= 0 && cell_q[1] < GRID_HEIGHT &&
	                 cell_q[2] >= 0 && cell_q[2] < GRID_SIDE;
	assign ram_raddr = addr_of(cell_q[0][AW-1:0], cell_q[1][AW-1:0], cell_q[2][AW-1:0]);
	assign walk_ok = !ti_q && t_q < TW'(reach);

	vrt_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// step axis: least tMax, ties go to the later axis (z over y over x)
	always_comb begin
		if (lt_u(tm_q[0], tmi_q[0], tm_q[1], tmi_q[1])) begin
			step_ax = lt_u(tm_q[0], tmi_q[0], tm_q[2], tmi_q[2]) ? 2'd0 : 2'd2;
		end else begin
			step_ax = lt_u(tm_q[1], tmi_q[1], tm_q[2], tmi_q[2]) ? 2'd1 : 2'd2;
		end
	end

	// struck face: axis whose last crossing (tMax - tDelta) is the earliest
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lc[i] = $signed({1'b0, tm_q[i]}) - $signed({1'b0, td_q[i]});
		end
		if (lt_s(lc[0], tdi_q[0], lc[1], tdi_q[1]) && lt_s(lc[0], tdi_q[0], lc[2], tdi_q[2])) begin
			face = dpos_q[0] ? FACE_LEFT : FACE_RIGHT;
		end else if (lt_s(lc[1], tdi_q[1], lc[2], tdi_q[2])) begin
			face = dpos_q[1] ? FACE_BOTTOM : FACE_TOP;
		end else begin
			face = dpos_q[2] ? FACE_BACK : FACE_FRONT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			outv_q  <= 1'b0;
			ax_q    <= '0;
			ph_q    <= 1'b0;
		end else begin
			// the output stage refills the slot itself when a word is issued
			if (pop && outv_q && state_q != S_OUT) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAP_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid && q_item.op == OP_CAST) begin
						ax_q    <= '0;
						ph_q    <= 1'b0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (mag_q[ax_q] == '0) begin
						ax_q <= ax_q + 1'b1;
						if (ax_q == 2'd2) begin
							state_q <= S_WALK;
						end
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (div_done) begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							ax_q    <= ax_q + 1'b1;
							state_q <= (ax_q == 2'd2) ? S_WALK : S_SETUP;
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_WALK: begin
					state_q <= walk_ok ? S_CHK : S_OUT;
				end
				S_CHK: begin
					state_q <= (ing_q && ram_rdata) ? S_OUT : S_WALK;
				end
				S_OUT: begin
					if (!outv_q || pop) begin
						outv_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					pos_q[i]  <= pos_in[i];
					mag_q[i]  <= dir_in[i][DIR_W-1] ? MAG_W'(-dir_in[i]) : MAG_W'(dir_in[i]);
					dpos_q[i] <= dir_in[i] > 0;
					cell_q[i] <= CELL_W'(pos_in[i] >> FRAC_BITS);
				end
				t_q  <= '0;
				ti_q <= 1'b0;
			end
			S_SETUP: begin
				if (mag_q[ax_q] == '0) begin
					tmi_q[ax_q] <= 1'b1;
					tdi_q[ax_q] <= 1'b1;
					tm_q[ax_q]  <= '0;
					td_q[ax_q]  <= '0;
				end
			end
			S_WAIT: begin
				if (div_done) begin
					if (!ph_q) begin
						tm_q[ax_q]  <= TW'(div_quo);
						tmi_q[ax_q] <= 1'b0;
					end else begin
						td_q[ax_q]  <= (div_quo == '0) ? TW'(1) : TW'(div_quo);
						tdi_q[ax_q] <= 1'b0;
					end
				end
			end
			S_WALK: begin
				ing_q <= cell_in;
				if (!walk_ok) begin
					res_q <= '0;
				end
			end
			S_CHK: begin
				if (ing_q && ram_rdata) begin
					res_q.hit  <= 1'b1;
					res_q.x    <= cell_q[0][VOX_W-1:0];
					res_q.y    <= cell_q[1][VOX_W-1:0];
					res_q.z    <= cell_q[2][VOX_W-1:0];
					res_q.face <= face;
				end else begin
					cell_q[step_ax] <= dpos_q[step_ax] ? cell_q[step_ax] + 1'b1
					                                   : cell_q[step_ax] - 1'b1;
					t_q  <= tm_q[step_ax];
					ti_q <= tmi_q[step_ax];
					tmi_q[step_ax] <= tmi_q[step_ax] | tdi_q[step_ax];
					tm_q[step_ax]  <= tm_q[step_ax] + td_q[step_ax];
				end
			end
			S_OUT: begin
				if (!outv_q || pop) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign clearing = state_q == S_CLEAR;
	assign empty    = !outv_q;
	assign result   = out_q;
endmodule

[src/vrt_checker.sv]
module vrt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       hit,
	input logic [5:0] hit_x,
	input logic [5:0] hit_y,
	input logic [5:0] hit_z,
	input logic [2:0] struck_face
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result word dropped without pop");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(hit) && $stable(hit_x) && $stable(hit_y) &&
		$stable(hit_z) && $stable(struck_face))
		else $error("waiting result word changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !hit |-> hit_x == 6'd0 && hit_y == 6'd0 && hit_z == 6'd0 &&
		struck_face == 3'd0)
		else $error("miss word carries nonzero fields");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && hit |-> struck_face <= 3'd5)
		else $error("struck face code out of range");
endmodule

bind voxel_ray_traversal_unit vrt_checker u_vrt_checker (.*);
